[hw/rtl/tpst_pkg.sv]
// ----------------------------------------------------------------------------
// tpst_pkg
// Shared types and constants of the transposition table probe store.
// ----------------------------------------------------------------------------
package tpst_pkg;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned DEPTH_W = 6;
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned BOUND_W = 2;

  typedef enum logic {
    ACT_STORE = 1'b0,
    ACT_PROBE = 1'b1
  } action_e;

  // Code 3 is kept as written but never gives a hit.
  typedef enum logic [BOUND_W-1:0] {
    BOUND_EXACT = 2'd0,
    BOUND_UPPER = 2'd1,
    BOUND_LOWER = 2'd2
  } bound_e;

  typedef struct packed {
    logic                      hit;
    logic signed [SCORE_W-1:0] score;
  } probe_res_t;

endpackage

[hw/rtl/tpst_mem.sv]
// ----------------------------------------------------------------------------
// tpst_mem
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module tpst_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 85
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/tpst_eval.sv]
// ----------------------------------------------------------------------------
// tpst_eval
// Hit decision and score selection for one probe against one read entry.
// ----------------------------------------------------------------------------
module tpst_eval #(
  parameter int unsigned STORED_DEPTH_W = 2
) (
  input  logic                              entry_valid_i,
  input  logic [tpst_pkg::KEY_W-1:0]        entry_key_i,
  input  logic [STORED_DEPTH_W-1:0]         entry_depth_i,
  input  logic signed [tpst_pkg::SCORE_W-1:0] entry_score_i,
  input  logic [tpst_pkg::BOUND_W-1:0]      entry_bound_i,
  input  logic [tpst_pkg::KEY_W-1:0]        probe_key_i,
  input  logic [tpst_pkg::DEPTH_W-1:0]      probe_depth_i,
  input  logic signed [tpst_pkg::SCORE_W-1:0] alpha_i,
  input  logic signed [tpst_pkg::SCORE_W-1:0] beta_i,
  output tpst_pkg::probe_res_t              res_o
);
  import tpst_pkg::*;

  logic [DEPTH_W-1:0] entry_depth_ext;
  logic               usable;

  assign entry_depth_ext = DEPTH_W'(entry_depth_i);
  assign usable = entry_valid_i && (entry_key_i == probe_key_i)
                  && (probe_depth_i <= entry_depth_ext);

  always_comb begin
    res_o = '0;
    if (usable) begin
      case (bound_e'(entry_bound_i))
        BOUND_EXACT: begin
          res_o.hit   = 1'b1;
          res_o.score = entry_score_i;
        end
        BOUND_UPPER: begin
          if (entry_score_i <= alpha_i) begin
            res_o.hit   = 1'b1;
            res_o.score = alpha_i;
          end
        end
        BOUND_LOWER: begin
          if (entry_score_i >= beta_i) begin
            res_o.hit   = 1'b1;
            res_o.score = beta_i;
          end
        end
        default: begin
          res_o = '0;
        end
      endcase
    end
  end

endmodule

[hw/rtl/transposition_table_probe_store_top.sv]
// ----------------------------------------------------------------------------
// transposition_table_probe_store_top
// Direct-mapped, always-replace transposition table with store and probe.
// ----------------------------------------------------------------------------
// Usage: each input item either stores an entry (no result) or probes the
// table (one result: hit and score). The slot is the low bits of the key, so
// TABLE_ENTRIES must be a power of two. The block takes one item per cycle
// when the output side keeps up; a probe's result passes the synchronous
// table read and then the compare and the output register. A store is
// written at the edge that takes it, so a probe in the very next cycle
// already reads the new entry. After reset a clearing pass writes every
// slot invalid, one slot a cycle; in_stall_o stays high while it runs.
// Stored depth saturates at MAX_STORED_DEPTH.
module transposition_table_probe_store_top #(
  parameter int unsigned TABLE_ENTRIES    = 4096,
  parameter int unsigned MAX_STORED_DEPTH = 3
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                action_i,
  input  logic [tpst_pkg::KEY_W-1:0]          key_i,
  input  logic [tpst_pkg::DEPTH_W-1:0]        depth_i,
  input  logic signed [tpst_pkg::SCORE_W-1:0] score_i,
  input  logic [tpst_pkg::BOUND_W-1:0]        bound_kind_i,
  input  logic signed [tpst_pkg::SCORE_W-1:0] alpha_limit_i,
  input  logic signed [tpst_pkg::SCORE_W-1:0] beta_limit_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                hit_o,
  output logic signed [tpst_pkg::SCORE_W-1:0] result_score_o
);
  import tpst_pkg::*;

  localparam int unsigned IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int unsigned SDW    = $clog2(MAX_STORED_DEPTH + 1);
  localparam int unsigned WORD_W = 1 + KEY_W + SDW + SCORE_W + BOUND_W;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   clr_idx_q, clr_idx_d;

  // probe waiting on its table read
  logic               s1_valid_q, s1_valid_d;
  logic [KEY_W-1:0]   s1_key_q;
  logic [DEPTH_W-1:0] s1_depth_q;
  logic signed [SCORE_W-1:0] s1_alpha_q, s1_beta_q;

  // output register
  logic               out_valid_q, out_valid_d;
  probe_res_t         out_q;

  logic               clearing, advance, accept, acc_store, acc_probe;
  logic [SDW-1:0]     sat_depth;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [WORD_W-1:0]  mem_wdata, mem_rdata;

  logic               rd_valid;
  logic [KEY_W-1:0]   rd_key;
  logic [SDW-1:0]     rd_depth;
  logic signed [SCORE_W-1:0] rd_score;
  logic [BOUND_W-1:0] rd_bound;
  probe_res_t         eval_res;

  assign clearing   = (state_q == ST_CLEAR);
  // s1 can move on unless the output register is full and held
  assign advance    = !(out_valid_q && out_stall_i);
  assign in_stall_o = clearing || (s1_valid_q && !advance);
  assign accept     = in_valid_i && !in_stall_o;
  assign acc_store  = accept && (action_i == ACT_STORE);
  assign acc_probe  = accept && (action_i == ACT_PROBE);

  assign sat_depth = (depth_i > DEPTH_W'(MAX_STORED_DEPTH)) ? SDW'(MAX_STORED_DEPTH)
                                                            : SDW'(depth_i);

  // clearing pass after reset, then normal operation
  always_comb begin
    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    case (state_q)
      ST_CLEAR: begin
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        clr_idx_d = clr_idx_q;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign mem_we    = clearing || acc_store;
  assign mem_waddr = clearing ? clr_idx_q : key_i[IDX_W-1:0];
  assign mem_wdata = clearing ? '0 : {1'b1, key_i, sat_depth, score_i, bound_kind_i};

  tpst_mem #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH (WORD_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (acc_probe),
    .raddr_i (key_i[IDX_W-1:0]),
    .rdata_o (mem_rdata)
  );

  assign {rd_valid, rd_key, rd_depth, rd_score, rd_bound} = mem_rdata;

  tpst_eval #(
    .STORED_DEPTH_W (SDW)
  ) u_eval (
    .entry_valid_i (rd_valid),
    .entry_key_i   (rd_key),
    .entry_depth_i (rd_depth),
    .entry_score_i (rd_score),
    .entry_bound_i (rd_bound),
    .probe_key_i   (s1_key_q),
    .probe_depth_i (s1_depth_q),
    .alpha_i       (s1_alpha_q),
    .beta_i        (s1_beta_q),
    .res_o         (eval_res)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (acc_probe) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_valid_q && advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (acc_probe) begin
      s1_key_q   <= key_i;
      s1_depth_q <= depth_i;
      s1_alpha_q <= alpha_limit_i;
      s1_beta_q  <= beta_limit_i;
    end
    if (s1_valid_q && advance) begin
      out_q <= eval_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = out_q.hit;
  assign result_score_o = out_q.score;

endmodule

[hw/rtl/tpst_checker.sv]
// ----------------------------------------------------------------------------
// tpst_checker
// Port-level checks of the transposition table probe store, bound to the top.
// ----------------------------------------------------------------------------
module tpst_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                action_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic                                hit_o,
  input logic signed [tpst_pkg::SCORE_W-1:0] result_score_o
);
  import tpst_pkg::*;

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a miss reports a zero score
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> result_score_o == '0)
    else $error("miss with non-zero score");

  // a taken probe has its result on offer once past the table read and the output register
  a_probe_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (action_i == ACT_PROBE) |-> ##2 out_valid_o)
    else $error("probe result missing");

  // table clearing blocks input right after reset
  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o)
    else $error("input taken during clearing pass");

endmodule

bind transposition_table_probe_store_top tpst_checker u_tpst_checker (.*);

[tb/sv/tb_transposition_table_probe_store_top.sv]
// ----------------------------------------------------------------------------
// tb_transposition_table_probe_store_top
// Self-checking bench for the transposition table: a short directed pass over
// depth limits, bound kinds and slot replacement, then random store/probe
// traffic, most of it with random gaps on both sides. Probe results are
// predicted by a shadow table and checked in order, field by field.
// ----------------------------------------------------------------------------
module tb_transposition_table_probe_store_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tpst_pkg::*;

  localparam int unsigned TT_ENTRIES   = 4096;
  localparam int unsigned TT_DEPTH_MAX = 3;
  localparam int unsigned SLOT_W       = $clog2(TT_ENTRIES);
  localparam int unsigned TT_DEPTH_W   = $clog2(TT_DEPTH_MAX + 1);
  // clearing pass plus ~1250 items with gaps and stalls, taken many times over
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned IDLE_PCT     = 18;
  // bound code with no enum member: stored, never hits
  localparam logic [BOUND_W-1:0] BOUND_SPARE = 2'd3;

  localparam logic signed [SCORE_W-1:0] SCORE_MIN = 16'sh8000;
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 16'sh7fff;

  typedef struct {
    action_e                   act;
    logic [KEY_W-1:0]          key;
    logic [DEPTH_W-1:0]        depth;
    logic signed [SCORE_W-1:0] score;
    logic [BOUND_W-1:0]        bound;
    logic signed [SCORE_W-1:0] alpha;
    logic signed [SCORE_W-1:0] beta;
  } tt_item_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT signals. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                      clk_i          = 1'b0;
  logic                      rst_ni         = 1'b0;
  logic                      in_valid_i     = 1'b0;
  logic                      in_stall_o;
  logic                      action_i       = 1'b0;
  logic [KEY_W-1:0]          key_i          = '0;
  logic [DEPTH_W-1:0]        depth_i        = '0;
  logic signed [SCORE_W-1:0] score_i        = '0;
  logic [BOUND_W-1:0]        bound_kind_i   = '0;
  logic signed [SCORE_W-1:0] alpha_limit_i  = '0;
  logic signed [SCORE_W-1:0] beta_limit_i   = '0;
  logic                      out_valid_o;
  logic                      out_stall_i    = 1'b0;
  logic                      hit_o;
  logic signed [SCORE_W-1:0] result_score_o;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  transposition_table_probe_store_top #(
    .TABLE_ENTRIES    (TT_ENTRIES),
    .MAX_STORED_DEPTH (TT_DEPTH_MAX)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .key_i          (key_i),
    .depth_i        (depth_i),
    .score_i        (score_i),
    .bound_kind_i   (bound_kind_i),
    .alpha_limit_i  (alpha_limit_i),
    .beta_limit_i   (beta_limit_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .result_score_o (result_score_o)
  );

  // --------------------------------------------------------------------------
  // Shadow table. bit storage keeps never-written slots at zero, which only
  // matters for aiming random windows; the valid mark gates every lookup.
  // --------------------------------------------------------------------------
  bit                      tt_valid [TT_ENTRIES];
  bit [KEY_W-1:0]          tt_key   [TT_ENTRIES];
  bit [TT_DEPTH_W-1:0]     tt_depth [TT_ENTRIES];
  bit signed [SCORE_W-1:0] tt_score [TT_ENTRIES];
  bit [BOUND_W-1:0]        tt_bound [TT_ENTRIES];

  probe_res_t       expected_probe_q [$];
  probe_res_t       exp_res;
  logic [KEY_W-1:0] stored_keys [$];    // recent store keys, for probes that match
  int unsigned      mismatch_count = 0;
  int unsigned      cycle_count    = 0;
  bit               gaps_on        = 1'b0;

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Apply one accepted item to the shadow table; a probe queues its result.
  task automatic predict_item(tt_item_t it);
    logic [SLOT_W-1:0] slot;
    probe_res_t        res;
    slot = it.key[SLOT_W-1:0];
    if (it.act == ACT_STORE) begin
      // always replace; deep stores saturate
      tt_valid[slot] = 1'b1;
      tt_key[slot]   = it.key;
      tt_depth[slot] = (it.depth > TT_DEPTH_MAX) ? TT_DEPTH_W'(TT_DEPTH_MAX)
                                                 : TT_DEPTH_W'(it.depth);
      tt_score[slot] = it.score;
      tt_bound[slot] = it.bound;
    end else begin
      res.hit   = 1'b0;
      res.score = '0;
      if (tt_valid[slot] && tt_key[slot] == it.key && it.depth <= tt_depth[slot]) begin
        case (tt_bound[slot])
          BOUND_EXACT: begin
            res.hit   = 1'b1;
            res.score = tt_score[slot];
          end
          BOUND_UPPER: begin
            if (tt_score[slot] <= it.alpha) begin
              res.hit   = 1'b1;
              res.score = it.alpha;
            end
          end
          BOUND_LOWER: begin
            if (tt_score[slot] >= it.beta) begin
              res.hit   = 1'b1;
              res.score = it.beta;
            end
          end
          default: ;
        endcase
      end
      expected_probe_q.push_back(res);
    end
  endtask

  // Unused fields carry random junk: stores ignore the window, probes ignore
  // score and bound kind.
  function automatic tt_item_t make_store(logic [KEY_W-1:0] k, logic [DEPTH_W-1:0] d,
                                          logic signed [SCORE_W-1:0] sc,
                                          logic [BOUND_W-1:0] b);
    tt_item_t it;
    it.act   = ACT_STORE;
    it.key   = k;
    it.depth = d;
    it.score = sc;
    it.bound = b;
    it.alpha = SCORE_W'($urandom);
    it.beta  = SCORE_W'($urandom);
    return it;
  endfunction

  function automatic tt_item_t make_probe(logic [KEY_W-1:0] k, logic [DEPTH_W-1:0] d,
                                          logic signed [SCORE_W-1:0] a,
                                          logic signed [SCORE_W-1:0] b);
    tt_item_t it;
    it.act   = ACT_PROBE;
    it.key   = k;
    it.depth = d;
    it.score = SCORE_W'($urandom);
    it.bound = BOUND_W'($urandom);
    it.alpha = a;
    it.beta  = b;
    return it;
  endfunction

  // Mostly shallow, so the saturated depth limit is crossed often.
  function automatic logic [DEPTH_W-1:0] rand_depth();
    return ($urandom_range(99) < 65) ? DEPTH_W'($urandom_range(4)) : DEPTH_W'($urandom);
  endfunction

  function automatic logic signed [SCORE_W-1:0] clip_score(int v);
    if (v > int'(SCORE_MAX)) return SCORE_MAX;
    if (v < int'(SCORE_MIN)) return SCORE_MIN;
    return SCORE_W'(v);
  endfunction

  // Called on a rising edge; returns on the edge that accepts the item, with
  // valid still high so a following item can go out back to back.
  task automatic send_item(tt_item_t it);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= it.act;
    key_i         <= it.key;
    depth_i       <= it.depth;
    score_i       <= it.score;
    bound_kind_i  <= it.bound;
    alpha_limit_i <= it.alpha;
    beta_limit_i  <= it.beta;
    do @(posedge clk_i); while (in_stall_o);
    predict_item(it);
  endtask

  // Output side stalls at random while gaps are on.
  always @(posedge clk_i) begin
    out_stall_i <= gaps_on && ($urandom_range(99) < IDLE_PCT);
  end

  // In-order check of every accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_probe_q.size() == 0) begin
        report_mismatch($sformatf("result with no probe pending: hit=%0b score=%0d",
                                  hit_o, result_score_o));
      end else begin
        exp_res = expected_probe_q.pop_front();
        if (hit_o !== exp_res.hit)
          report_mismatch($sformatf("hit %0b, expected %0b", hit_o, exp_res.hit));
        if (result_score_o !== exp_res.score)
          report_mismatch($sformatf("result_score %0d, expected %0d",
                                    result_score_o, exp_res.score));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed tests. Run with no gaps so stores and probes go back to back,
  // which covers a probe that reads the entry stored just before it.
  // --------------------------------------------------------------------------
  localparam logic [KEY_W-1:0] KEY_A = 64'h0123_4567_89ab_c005;
  localparam logic [KEY_W-1:0] KEY_B = 64'hfedc_ba98_7654_3005; // same slot as KEY_A
  localparam logic [KEY_W-1:0] KEY_C = 64'h5555_aaaa_5555_a7ff;
  localparam logic [KEY_W-1:0] KEY_D = 64'h8000_0000_0000_0010;
  localparam logic [KEY_W-1:0] KEY_E = 64'h0000_0000_0000_0fe1;
  localparam logic [KEY_W-1:0] KEY_F = 64'h7fff_ffff_ffff_f3c2;

  // Every slot is invalid after the clearing pass: probes miss.
  task automatic test_empty_table();
    send_item(make_probe('0, '0, SCORE_MIN, SCORE_MAX));
    send_item(make_probe('1, '1, SCORE_MIN, SCORE_MAX));
  endtask

  // Deep store saturates to the maximum depth; exact bound returns the score.
  task automatic test_exact_and_depth();
    send_item(make_store(KEY_A, '1, SCORE_MIN, BOUND_EXACT));
    send_item(make_probe(KEY_A, DEPTH_W'(TT_DEPTH_MAX), SCORE_MIN, SCORE_MAX));
    send_item(make_probe(KEY_A, DEPTH_W'(TT_DEPTH_MAX + 1), SCORE_MIN, SCORE_MAX));
    send_item(make_probe(KEY_A, '0, SCORE_MAX, SCORE_MIN));
    send_item(make_store(KEY_C, '0, SCORE_MAX, BOUND_EXACT));
    send_item(make_probe(KEY_C, '0, SCORE_MIN, SCORE_MAX));
    send_item(make_probe(KEY_C, DEPTH_W'(1), SCORE_MIN, SCORE_MAX));
  endtask

  // Upper bound hits at or below alpha, lower bound at or above beta,
  // the spare code never.
  task automatic test_bound_kinds();
    send_item(make_store(KEY_D, DEPTH_W'(2), 16'sd100, BOUND_UPPER));
    send_item(make_probe(KEY_D, DEPTH_W'(2), 16'sd100, SCORE_MIN));
    send_item(make_probe(KEY_D, DEPTH_W'(2), 16'sd99, SCORE_MAX));
    send_item(make_probe(KEY_D, DEPTH_W'(1), SCORE_MAX, SCORE_MIN));
    send_item(make_store(KEY_E, DEPTH_W'(1), -16'sd5, BOUND_LOWER));
    send_item(make_probe(KEY_E, DEPTH_W'(1), SCORE_MAX, -16'sd5));
    send_item(make_probe(KEY_E, DEPTH_W'(1), SCORE_MIN, -16'sd4));
    send_item(make_probe(KEY_E, '0, SCORE_MAX, SCORE_MIN));
    send_item(make_store(KEY_F, DEPTH_W'(3), 16'sd7, BOUND_SPARE));
    send_item(make_probe(KEY_F, '0, SCORE_MAX, SCORE_MIN));
  endtask

  // A store to an occupied slot replaces the old entry; the old key misses.
  task automatic test_slot_replace();
    send_item(make_store(KEY_B, DEPTH_W'(1), 16'sd55, BOUND_EXACT));
    send_item(make_probe(KEY_A, '0, SCORE_MIN, SCORE_MAX));
    send_item(make_probe(KEY_B, DEPTH_W'(1), SCORE_MIN, SCORE_MAX));
  endtask

  // --------------------------------------------------------------------------
  // Random traffic: stores, often into a few hot slots to force replacement,
  // and probes that mostly hit recent keys with windows aimed at the stored
  // score; the rest alias the slot with a changed key or use a fresh key.
  // --------------------------------------------------------------------------
  task automatic test_random_traffic(int unsigned n_items, bit with_gaps);
    tt_item_t          it;
    logic [KEY_W-1:0]  k;
    logic [SLOT_W-1:0] slot;
    int unsigned       sel;
    int                aim;
    logic signed [SCORE_W-1:0] a;
    logic signed [SCORE_W-1:0] b;
    gaps_on <= with_gaps;
    for (int unsigned i = 0; i < n_items; i++) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        k = {$urandom, $urandom};
        if ($urandom_range(99) < 35)
          k[SLOT_W-1:0] = SLOT_W'($urandom_range(15));
        it = make_store(k, rand_depth(), SCORE_W'($urandom), BOUND_W'($urandom_range(3)));
        stored_keys.push_back(k);
        if (stored_keys.size() > 48)
          void'(stored_keys.pop_front());
      end else begin
        if (stored_keys.size() != 0 && sel < 88)
          k = stored_keys[$urandom_range(stored_keys.size() - 1)];
        else
          k = {$urandom, $urandom};
        // same slot, different key: must miss on the full key compare
        if (sel >= 80 && sel < 88)
          k = k ^ (64'd1 << $urandom_range(KEY_W - 1, SLOT_W));
        slot = k[SLOT_W-1:0];
        aim  = int'(tt_score[slot]);
        a    = ($urandom_range(1) != 0) ? clip_score(aim + int'($urandom_range(4)) - 2)
                                        : SCORE_W'($urandom);
        b    = ($urandom_range(1) != 0) ? clip_score(aim + int'($urandom_range(4)) - 2)
                                        : SCORE_W'($urandom);
        it = make_probe(k, rand_depth(), a, b);
      end
      send_item(it);
    end
  endtask

  // Hard stop on a hang.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // the clearing pass holds in_stall_o high; send_item waits it out
    test_empty_table();
    test_exact_and_depth();
    test_bound_kinds();
    test_slot_replace();
    test_random_traffic(500, 1'b1);
    test_random_traffic(300, 1'b0);   // long stretch with no idling
    test_random_traffic(400, 1'b1);
    in_valid_i <= 1'b0;
    for (int unsigned w = 0; w < 2000 && expected_probe_q.size() != 0; w++)
      @(posedge clk_i);
    if (expected_probe_q.size() != 0)
      report_mismatch($sformatf("%0d probe results never arrived", expected_probe_q.size()));
    // a few spare edges catch stray results
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
